// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLKD(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) expr) else $error(msg);

// assertion on the default clock and reset names
`define ASSERT_STD(lbl, expr, msg) \
   `ASSERT_CLKD(lbl, clock, reset, expr, msg)

`endif

// ----- sv/pcan_pkg.sv -----
// ----------------------------------------------------------------------------
// pcan_pkg
// Types and codes shared by the path canonicalizer controller and datapath.
// ----------------------------------------------------------------------------
package pcan_pkg;

   localparam logic [1:0] OP_PATH   = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_COMMIT = 2'd2;

   localparam logic [1:0] ST_PEND = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   localparam logic [7:0] SLASH = 8'h2F;
   localparam logic [7:0] DOT   = 8'h2E;

   localparam logic [1:0] CL_NONE = 2'd0;
   localparam logic [1:0] CL_POP  = 2'd1;
   localparam logic [1:0] CL_APP  = 2'd2;

   localparam logic [4:0] ACT_NONE   = 5'd0;
   localparam logic [4:0] ACT_ACCEPT = 5'd1;
   localparam logic [4:0] ACT_START  = 5'd2;
   localparam logic [4:0] ACT_WCP_RD = 5'd3;
   localparam logic [4:0] ACT_WCP_WR = 5'd4;
   localparam logic [4:0] ACT_BYTE   = 5'd5;
   localparam logic [4:0] ACT_CLOSE  = 5'd6;
   localparam logic [4:0] ACT_POP_RD = 5'd7;
   localparam logic [4:0] ACT_POP_CK = 5'd8;
   localparam logic [4:0] ACT_APP_RD = 5'd9;
   localparam logic [4:0] ACT_APP_WR = 5'd10;
   localparam logic [4:0] ACT_CDONE  = 5'd11;
   localparam logic [4:0] ACT_LAST   = 5'd12;
   localparam logic [4:0] ACT_RD     = 5'd13;
   localparam logic [4:0] ACT_RDW    = 5'd14;
   localparam logic [4:0] ACT_COMMIT = 5'd15;
   localparam logic [4:0] ACT_CCP_RD = 5'd16;
   localparam logic [4:0] ACT_CCP_WR = 5'd17;
   localparam logic [4:0] ACT_OUT    = 5'd18;

   typedef struct packed {
      logic [4:0] act;
   } pcan_cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       need_start;
      logic       start_copy;
      logic       is_slash;
      logic       last;
      logic       commit_copy;
      logic [1:0] cl_kind;
      logic       wcp_done;
      logic       app_done;
      logic       ccp_done;
      logic       pop_hit;
      logic       rsp_free;
   } pcan_stat_type;

endpackage

// ----- sv/pcan_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcan_ctrl
// Sequencer: steps one beat through decode, store copies, pops, appends and output.
// ----------------------------------------------------------------------------
module pcan_ctrl
   import pcan_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  pcan_stat_type stat,
   output pcan_cmd_type  cmd
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DEC    = 5'd1;
   localparam logic [4:0] S_WCP_RD = 5'd2;
   localparam logic [4:0] S_WCP_WR = 5'd3;
   localparam logic [4:0] S_BYTE   = 5'd4;
   localparam logic [4:0] S_CLOSE  = 5'd5;
   localparam logic [4:0] S_POP_RD = 5'd6;
   localparam logic [4:0] S_POP_CK = 5'd7;
   localparam logic [4:0] S_APP_RD = 5'd8;
   localparam logic [4:0] S_APP_WR = 5'd9;
   localparam logic [4:0] S_CDONE  = 5'd10;
   localparam logic [4:0] S_LAST   = 5'd11;
   localparam logic [4:0] S_RD     = 5'd12;
   localparam logic [4:0] S_RDW    = 5'd13;
   localparam logic [4:0] S_CCP_RD = 5'd14;
   localparam logic [4:0] S_CCP_WR = 5'd15;
   localparam logic [4:0] S_OUT    = 5'd16;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.act  = ACT_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.act  = ACT_ACCEPT;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            case (stat.opcode)
               OP_PATH: begin
                  if (stat.need_start) begin
                     cmd.act  = ACT_START;
                     state_in = stat.start_copy ? S_WCP_RD : S_BYTE;
                  end else begin
                     state_in = S_BYTE;
                  end
               end
               OP_READ: begin
                  cmd.act  = ACT_RD;
                  state_in = S_RD;
               end
               OP_COMMIT: begin
                  cmd.act  = ACT_COMMIT;
                  state_in = stat.commit_copy ? S_CCP_RD : S_OUT;
               end
               default: state_in = S_OUT;
            endcase
         end
         S_RD: begin
            state_in = S_RDW;
         end
         S_RDW: begin
            cmd.act  = ACT_RDW;
            state_in = S_OUT;
         end
         S_WCP_RD: begin
            cmd.act  = ACT_WCP_RD;
            state_in = S_WCP_WR;
         end
         S_WCP_WR: begin
            cmd.act  = ACT_WCP_WR;
            state_in = stat.wcp_done ? S_BYTE : S_WCP_RD;
         end
         S_BYTE: begin
            cmd.act  = ACT_BYTE;
            state_in = (stat.is_slash || stat.last) ? S_CLOSE : S_OUT;
         end
         S_CLOSE: begin
            cmd.act = ACT_CLOSE;
            case (stat.cl_kind)
               CL_POP:  state_in = S_POP_RD;
               CL_APP:  state_in = S_APP_RD;
               default: state_in = S_CDONE;
            endcase
         end
         S_POP_RD: begin
            cmd.act  = ACT_POP_RD;
            state_in = S_POP_CK;
         end
         S_POP_CK: begin
            cmd.act  = ACT_POP_CK;
            state_in = stat.pop_hit ? S_CDONE : S_POP_RD;
         end
         S_APP_RD: begin
            cmd.act  = ACT_APP_RD;
            state_in = S_APP_WR;
         end
         S_APP_WR: begin
            cmd.act  = ACT_APP_WR;
            state_in = stat.app_done ? S_CDONE : S_APP_RD;
         end
         S_CDONE: begin
            cmd.act  = ACT_CDONE;
            state_in = stat.last ? S_LAST : S_OUT;
         end
         S_LAST: begin
            cmd.act  = ACT_LAST;
            state_in = S_OUT;
         end
         S_CCP_RD: begin
            cmd.act  = ACT_CCP_RD;
            state_in = S_CCP_WR;
         end
         S_CCP_WR: begin
            cmd.act  = ACT_CCP_WR;
            state_in = stat.ccp_done ? S_OUT : S_CCP_RD;
         end
         S_OUT: begin
            if (stat.rsp_free) begin
               cmd.act  = ACT_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/pcan_dp.sv -----
// ----------------------------------------------------------------------------
// pcan_dp
// Datapath: working directory, result and component stores, lengths,
// counters and the output register.
// ----------------------------------------------------------------------------
module pcan_dp
   import pcan_pkg::*;
#(
   parameter int PATH_BYTES      = 128,
   parameter int COMPONENT_BYTES = 32
)
(
   input  logic          clock,
   input  logic          reset,
   input  pcan_cmd_type  cmd,
   output pcan_stat_type stat,
   input  logic [1:0]    req_opcode,
   input  logic [7:0]    req_path_byte,
   input  logic          req_last_byte,
   input  logic [7:0]    req_result_limit,
   input  logic [6:0]    req_read_index,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_status,
   output logic [6:0]    rsp_result_length,
   output logic [7:0]    rsp_data_byte
);

   localparam int AW = $clog2(PATH_BYTES);
   localparam int LW = AW + 1;
   localparam int CW = $clog2(COMPONENT_BYTES);
   localparam int SW = ((LW > CW) ? LW : CW) + 1;
   localparam int KW = (LW > 8) ? LW : 8;

   logic [7:0] wd_mem [PATH_BYTES];
   logic [7:0] rs_mem [PATH_BYTES];
   logic [7:0] cs_mem [COMPONENT_BYTES];

   logic [7:0]    wd_q_ff, rs_q_ff, cs_q_ff;
   logic          rs_z_ff;

   logic [LW-1:0] wd_len_ff, wd_len_in;
   logic          wd_tail_ff, wd_tail_in;
   logic [LW-1:0] res_len_ff, res_len_in;
   logic          res_tail_ff, res_tail_in;
   logic [CW-1:0] seg_len_ff, seg_len_in;
   logic          dot0_ff, dot0_in, dot1_ff, dot1_in;
   logic [LW-1:0] seen_ff, seen_in;
   logic          ovf_ff, ovf_in;
   logic [LW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    st_ff, st_in;
   logic [7:0]    data_ff, data_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff;
   logic [6:0]    rsp_len_ff;
   logic [7:0]    rsp_data_ff;
   logic [1:0]    op_ff;
   logic [7:0]    byte_ff;
   logic          last_ff;
   logic [7:0]    limit_ff;
   logic [6:0]    index_ff;

   logic          rs_we, rs_re, wd_we, wd_re, cs_we, cs_re;
   logic [AW-1:0] rs_wa, rs_ra, wd_wa, wd_ra;
   logic [7:0]    rs_wd;
   logic [7:0]    rs_rd;
   logic          is_dot1, is_dot2, joiner, fits, plain, room;
   logic [SW-1:0] app_sum;
   logic [1:0]    cl_kind;
   logic          eligible, idx_ok, lim_fail;

   assign rs_rd    = rs_z_ff ? SLASH : rs_q_ff;
   assign is_dot1  = (seg_len_ff == CW'(1)) && dot0_ff;
   assign is_dot2  = (seg_len_ff == CW'(2)) && dot0_ff && dot1_ff;
   assign joiner   = (res_len_ff > LW'(1)) && !res_tail_ff;
   assign app_sum  = SW'(res_len_ff) + SW'(joiner) + SW'(seg_len_ff);
   assign fits     = app_sum < SW'(PATH_BYTES);
   assign plain    = !ovf_ff && (seg_len_ff != '0) && !is_dot1 && !is_dot2;
   assign room     = seg_len_ff < CW'(COMPONENT_BYTES - 1);
   assign eligible = (seen_ff == '0) && !ovf_ff && (res_len_ff < LW'(PATH_BYTES));
   assign idx_ok   = KW'(index_ff) < KW'(res_len_ff);
   assign lim_fail = KW'(res_len_ff) >= KW'(limit_ff);

   always_comb begin
      if (plain && fits) begin
         cl_kind = CL_APP;
      end else if (!ovf_ff && is_dot2 && (res_len_ff > LW'(1))) begin
         cl_kind = CL_POP;
      end else begin
         cl_kind = CL_NONE;
      end
   end

   always_comb begin
      stat.opcode      = op_ff;
      stat.need_start  = (seen_ff == '0);
      stat.start_copy  = (byte_ff != SLASH) && (wd_len_ff > LW'(1));
      stat.is_slash    = (byte_ff == SLASH);
      stat.last        = last_ff;
      stat.commit_copy = eligible && (res_len_ff > LW'(1));
      stat.cl_kind     = cl_kind;
      stat.wcp_done    = (ptr_ff + LW'(1)) >= wd_len_ff;
      stat.app_done    = (cnt_ff + CW'(1)) == seg_len_ff;
      stat.ccp_done    = (ptr_ff + LW'(1)) >= wd_len_ff;
      stat.pop_hit     = (rs_rd == SLASH);
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // store ports
   always_comb begin
      rs_we = 1'b0;
      rs_wa = ptr_ff[AW-1:0];
      rs_wd = wd_q_ff;
      rs_re = 1'b0;
      rs_ra = ptr_ff[AW-1:0];
      wd_we = 1'b0;
      wd_wa = ptr_ff[AW-1:0];
      wd_re = 1'b0;
      wd_ra = ptr_ff[AW-1:0];
      cs_we = 1'b0;
      cs_re = 1'b0;
      case (cmd.act)
         ACT_WCP_RD: wd_re = 1'b1;
         ACT_WCP_WR: rs_we = 1'b1;
         ACT_CLOSE: begin
            if (cl_kind == CL_APP && joiner) begin
               rs_we = 1'b1;
               rs_wa = res_len_ff[AW-1:0];
               rs_wd = SLASH;
            end
         end
         ACT_APP_RD: cs_re = 1'b1;
         ACT_APP_WR: begin
            rs_we = 1'b1;
            rs_wd = cs_q_ff;
         end
         ACT_POP_RD: begin
            rs_re = 1'b1;
            rs_ra = AW'(res_len_ff - LW'(1));
         end
         ACT_RD: begin
            rs_re = 1'b1;
            rs_ra = AW'(index_ff);
         end
         ACT_CCP_RD: rs_re = 1'b1;
         ACT_CCP_WR: wd_we = 1'b1;
         ACT_BYTE:   cs_we = (byte_ff != SLASH) && room;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rs_we) begin
         rs_mem[rs_wa] <= rs_wd;
      end
      if (rs_re) begin
         rs_q_ff <= rs_mem[rs_ra];
         rs_z_ff <= (rs_ra == '0);
      end
      if (wd_we) begin
         wd_mem[wd_wa] <= rs_rd;
      end
      if (wd_re) begin
         wd_q_ff <= wd_mem[wd_ra];
      end
      if (cs_we) begin
         cs_mem[seg_len_ff] <= byte_ff;
      end
      if (cs_re) begin
         cs_q_ff <= cs_mem[cnt_ff];
      end
   end

   always_comb begin
      wd_len_in    = wd_len_ff;
      wd_tail_in   = wd_tail_ff;
      res_len_in   = res_len_ff;
      res_tail_in  = res_tail_ff;
      seg_len_in   = seg_len_ff;
      dot0_in      = dot0_ff;
      dot1_in      = dot1_ff;
      seen_in      = seen_ff;
      ovf_in       = ovf_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      st_in        = st_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (cmd.act)
         ACT_ACCEPT: begin
            st_in   = ST_PEND;
            data_in = '0;
         end
         ACT_START: begin
            ovf_in     = 1'b0;
            seg_len_in = '0;
            ptr_in     = LW'(1);
            if (byte_ff == SLASH) begin
               res_len_in  = LW'(1);
               res_tail_in = 1'b1;
               seen_in     = '0;
            end else begin
               res_len_in  = (wd_tail_ff && wd_len_ff > LW'(1)) ?
                             wd_len_ff - LW'(1) : wd_len_ff;
               res_tail_in = (wd_len_ff == LW'(1));
               seen_in     = wd_tail_ff ? wd_len_ff : wd_len_ff + LW'(1);
            end
         end
         ACT_WCP_WR: ptr_in = ptr_ff + LW'(1);
         ACT_BYTE: begin
            if (seen_ff < LW'(PATH_BYTES)) begin
               seen_in = seen_ff + LW'(1);
            end
            if (byte_ff != SLASH && room) begin
               seg_len_in = seg_len_ff + CW'(1);
               if (seg_len_ff == '0) begin
                  dot0_in = (byte_ff == DOT);
               end
               if (seg_len_ff == CW'(1)) begin
                  dot1_in = (byte_ff == DOT);
               end
            end
         end
         ACT_CLOSE: begin
            case (cl_kind)
               CL_POP: begin
                  res_len_in  = res_len_ff - LW'(1);
                  res_tail_in = 1'b1;
               end
               CL_APP: begin
                  ptr_in      = res_len_ff + LW'(joiner);
                  res_len_in  = LW'(app_sum);
                  res_tail_in = 1'b0;
                  cnt_in      = '0;
               end
               default: begin
                  if (plain) begin
                     ovf_in = 1'b1;
                  end
               end
            endcase
         end
         ACT_POP_CK: begin
            if (!(rs_rd == SLASH)) begin
               res_len_in = res_len_ff - LW'(1);
            end
         end
         ACT_APP_WR: begin
            ptr_in = ptr_ff + LW'(1);
            cnt_in = cnt_ff + CW'(1);
         end
         ACT_CDONE: begin
            seg_len_in = '0;
            dot0_in    = 1'b0;
            dot1_in    = 1'b0;
         end
         ACT_LAST: begin
            seen_in = '0;
            if (ovf_ff || seen_ff >= LW'(PATH_BYTES) || lim_fail) begin
               ovf_in = 1'b1;
               st_in  = ST_ERR;
            end else begin
               st_in  = ST_DONE;
            end
         end
         ACT_RDW: data_in = idx_ok ? rs_rd : 8'd0;
         ACT_COMMIT: begin
            if (eligible) begin
               wd_len_in  = res_len_ff;
               wd_tail_in = res_tail_ff;
               ptr_in     = LW'(1);
            end
         end
         ACT_CCP_WR: ptr_in = ptr_ff + LW'(1);
         ACT_OUT:    rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wd_len_ff    <= LW'(1);
         wd_tail_ff   <= 1'b1;
         res_len_ff   <= LW'(1);
         res_tail_ff  <= 1'b1;
         seg_len_ff   <= '0;
         dot0_ff      <= 1'b0;
         dot1_ff      <= 1'b0;
         seen_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wd_len_ff    <= wd_len_in;
         wd_tail_ff   <= wd_tail_in;
         res_len_ff   <= res_len_in;
         res_tail_ff  <= res_tail_in;
         seg_len_ff   <= seg_len_in;
         dot0_ff      <= dot0_in;
         dot1_ff      <= dot1_in;
         seen_ff      <= seen_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      cnt_ff  <= cnt_in;
      st_ff   <= st_in;
      data_ff <= data_in;
      if (cmd.act == ACT_ACCEPT) begin
         op_ff    <= req_opcode;
         byte_ff  <= req_path_byte;
         last_ff  <= req_last_byte;
         limit_ff <= req_result_limit;
         index_ff <= req_read_index;
      end
      if (cmd.act == ACT_OUT) begin
         rsp_status_ff <= st_ff;
         rsp_len_ff    <= 7'(res_len_ff);
         rsp_data_ff   <= data_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_length = rsp_len_ff;
   assign rsp_data_byte     = rsp_data_ff;

endmodule

// ----- sv/path_canonicalizer_unit.sv -----
// One beat at a time: req_ready is high only while idle, and a response is held
// until rsp_ready. A byte that closes a component also steps through each
// appended byte, each byte scanned back on a dot-dot and, on a relative first
// byte, each working-directory byte past the root. A commit steps through each
// result byte past the root. Synchronous reset; stores need no clearing pass.
// ----------------------------------------------------------------------------
// path_canonicalizer_unit
// Canonicalizes a byte-serial path against a stored working directory.
// ----------------------------------------------------------------------------
module path_canonicalizer_unit
   import pcan_pkg::*;
#(
   parameter int PATH_BYTES      = 128,
   parameter int COMPONENT_BYTES = 32
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_path_byte,
   input  logic       req_last_byte,
   input  logic [7:0] req_result_limit,
   input  logic [6:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [6:0] rsp_result_length,
   output logic [7:0] rsp_data_byte
);

   pcan_cmd_type  cmd;
   pcan_stat_type stat;

   pcan_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcan_dp #(
      .PATH_BYTES      (PATH_BYTES),
      .COMPONENT_BYTES (COMPONENT_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_opcode),
      .req_path_byte     (req_path_byte),
      .req_last_byte     (req_last_byte),
      .req_result_limit  (req_result_limit),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_result_length (rsp_result_length),
      .rsp_data_byte     (rsp_data_byte)
   );

endmodule

// ----- sv/pcan_checker.sv -----
// ----------------------------------------------------------------------------
// pcan_checker
// Port-level checks for the path canonicalizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcan_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_result_length
);

   // one beat in flight: busy right after an accept
   `ASSERT_STD(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready, "ready after accept")

   // result always holds at least the root
   `ASSERT_STD(a_len_nonzero, rsp_valid |-> (rsp_result_length != 7'd0), "zero result length")

   `ASSERT_STD(a_rsp_hold, (rsp_valid && !rsp_ready) |=> rsp_valid, "response dropped")

endmodule

bind path_canonicalizer_unit pcan_checker u_pcan_checker (.*);

// ----- tb/sv/path_canonicalizer_unit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_canonicalizer_unit_checker
// Watches both channels, predicts each response beat from its own copy of
// the working directory and result buffers, and compares field by field.
// ----------------------------------------------------------------------------
module path_canonicalizer_unit_checker
   import pcan_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_path_byte,
   input  logic       req_last_byte,
   input  logic [7:0] req_result_limit,
   input  logic [6:0] req_read_index,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_status,
   input  logic [6:0] rsp_result_length,
   input  logic [7:0] rsp_data_byte,
   output int         fail_count,
   output int         pending
);

   localparam int PATH_MAX = 128;
   localparam int COMP_MAX = 32;

   typedef struct packed {
      logic [1:0] status;
      logic [6:0] length;
      logic [7:0] data;
   } canon_beat_type;

   canon_beat_type canon_q[$];

   logic [7:0] cwd[PATH_MAX];
   int         cwd_len;
   logic [7:0] canon[PATH_MAX];
   int         canon_len;
   logic [7:0] comp[COMP_MAX];
   int         part_len;
   int         seen;
   bit         too_long;
   int         errs;

   function void end_component();
      int n;
      int pos;
      int joiner;
      n = part_len;
      part_len = 0;
      if (too_long || n == 0) return;
      if (n == 1 && comp[0] == DOT) return;
      if (n == 2 && comp[0] == DOT && comp[1] == DOT) begin
         if (canon_len > 1) begin
            canon_len--;
            while (canon_len > 0 && canon[canon_len-1] != SLASH) canon_len--;
            if (canon_len == 0) canon_len = 1;
         end
         return;
      end
      pos = canon_len;
      joiner = (pos > 1 && canon[pos-1] != SLASH) ? 1 : 0;
      if (pos + joiner + n >= PATH_MAX) begin
         too_long = 1;
         return;
      end
      if (joiner != 0) begin
         canon[pos] = SLASH;
         pos++;
      end
      for (int j = 0; j < n; j++) canon[pos+j] = comp[j];
      canon_len = pos + n;
   endfunction

   function void begin_path(logic [7:0] first);
      too_long = 0;
      part_len = 0;
      if (first == SLASH || cwd_len == 0 || cwd_len >= PATH_MAX) begin
         canon[0] = SLASH;
         canon_len = 1;
         seen = 0;
         return;
      end
      for (int j = 0; j < cwd_len; j++) canon[j] = cwd[j];
      canon_len = cwd_len;
      if (cwd[cwd_len-1] == SLASH) begin
         seen = cwd_len;
         if (canon_len > 1) canon_len--;
      end else begin
         seen = cwd_len + 1;
      end
   endfunction

   function canon_beat_type canon_step(logic [1:0] op, logic [7:0] b, logic last,
                                       logic [7:0] limit, logic [6:0] idx);
      canon_beat_type r;
      r = '0;
      r.status = ST_PEND;
      if (op == OP_PATH) begin
         if (seen == 0) begin_path(b);
         if (seen < PATH_MAX) seen++;
         if (b == SLASH) begin
            end_component();
         end else if (part_len < COMP_MAX - 1) begin
            comp[part_len] = b;
            part_len++;
         end
         if (last) begin
            end_component();
            if (too_long || seen >= PATH_MAX || canon_len >= int'(limit)) begin
               too_long = 1;
               r.status = ST_ERR;
            end else begin
               r.status = ST_DONE;
            end
            seen = 0;
         end
      end else if (op == OP_READ) begin
         if (int'(idx) < canon_len) r.data = canon[idx];
      end else if (op == OP_COMMIT) begin
         if (seen == 0 && !too_long && canon_len >= 1 && canon_len < PATH_MAX) begin
            for (int j = 0; j < canon_len; j++) cwd[j] = canon[j];
            cwd_len = canon_len;
         end
      end
      r.length = canon_len[6:0];
      return r;
   endfunction

   always @(posedge clock) begin
      canon_beat_type want;
      canon_beat_type got;
      if (reset) begin
         canon_q.delete();
         cwd[0] = SLASH;
         cwd_len = 1;
         canon[0] = SLASH;
         canon_len = 1;
         part_len = 0;
         seen = 0;
         too_long = 0;
         errs = 0;
      end else begin
         if (req_valid && req_ready)
            canon_q.push_back(canon_step(req_opcode, req_path_byte, req_last_byte,
                                         req_result_limit, req_read_index));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_result_length, rsp_data_byte};
            if (canon_q.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("unexpected beat: status %0d length %0d data %h",
                           got.status, got.length, got.data);
            end else begin
               want = canon_q.pop_front();
               if (want !== got) begin
                  errs++;
                  if (errs <= 10)
                     $display("beat differs: expected %0d/%0d/%h got %0d/%0d/%h",
                              want.status, want.length, want.data,
                              got.status, got.length, got.data);
               end
            end
         end
      end
      fail_count <= errs;
      pending <= canon_q.size();
   end

endmodule

// ----- tb/sv/path_canonicalizer_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_canonicalizer_unit_tb
// Drives directed and random paths, reads and commits into the canonicalizer
// with random gaps and backpressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module path_canonicalizer_unit_tb;
   import pcan_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_opcode;
   logic [7:0] req_path_byte;
   logic       req_last_byte;
   logic [7:0] req_result_limit;
   logic [6:0] req_read_index;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_status;
   logic [6:0] rsp_result_length;
   logic [7:0] rsp_data_byte;
   int         fail_count;
   int         pending;
   int         sent;
   bit         steady;

   path_canonicalizer_unit uut (.*);

   path_canonicalizer_unit_checker chk (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= steady || ($urandom_range(99) >= 28);
   end

   task automatic send_beat(logic [1:0] op, logic [7:0] b, logic last,
                            logic [7:0] limit, logic [6:0] idx);
      if (!steady && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_path_byte    <= b;
      req_last_byte    <= last;
      req_result_limit <= limit;
      req_read_index   <= idx;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic send_path(string p, logic [7:0] limit);
      for (int i = 0; i < p.len(); i++)
         send_beat(OP_PATH, p[i], i == p.len() - 1, limit, 7'($urandom));
   endtask

   function automatic string rand_path();
      string p;
      int    n;
      int    k;
      if ($urandom_range(2) == 0) p = "/";
      else p = "";
      n = $urandom_range(1, 6);
      for (int c = 0; c < n; c++) begin
         k = $urandom_range(9);
         case (k)
            0: p = {p, ".."};
            1: p = {p, "."};
            2: p = {p, ""};
            3: for (int j = $urandom_range(25, 40); j > 0; j--) p = {p, "x"};
            4: for (int j = $urandom_range(1, 4); j > 0; j--) p = {p, string'(byte'($urandom))};
            default: for (int j = $urandom_range(1, 6); j > 0; j--)
               p = {p, string'(byte'($urandom_range(97, 100)))};
         endcase
         if (c != n - 1 || $urandom_range(3) == 0) p = {p, "/"};
      end
      if (p.len() == 0) p = "a";
      return p;
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      string p;
      req_valid = 1'b0;
      req_opcode = OP_PATH;
      req_path_byte = 8'd0;
      req_last_byte = 1'b0;
      req_result_limit = 8'd0;
      req_read_index = 7'd0;
      reset = 1'b1;
      steady = 0;
      sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_path("/", 8'd128);
      send_path("..", 8'd128);
      send_path("/ab/./c/../d/", 8'd255);
      send_beat(OP_READ, 8'h00, 1'b0, 8'd0, 7'd0);
      send_beat(OP_READ, 8'hFF, 1'b1, 8'hFF, 7'd127);
      send_beat(OP_COMMIT, 8'h00, 1'b0, 8'd0, 7'd0);
      send_path("e", 8'd128);
      send_beat(OP_COMMIT, 8'h00, 1'b0, 8'd0, 7'd0);
      send_beat(OP_UNUSED, 8'hFF, 1'b1, 8'hFF, 7'h7F);
      send_beat(OP_PATH, 8'h00, 1'b0, 8'd128, 7'd0);
      send_beat(OP_READ, 8'h00, 1'b0, 8'd128, 7'd1);
      send_beat(OP_COMMIT, 8'h00, 1'b0, 8'd128, 7'd0);
      send_beat(OP_PATH, 8'hFF, 1'b1, 8'd128, 7'd0);
      send_path("/q", 8'd0);
      send_beat(OP_COMMIT, 8'h00, 1'b0, 8'd0, 7'd0);
      p = "/";
      for (int i = 0; i < 140; i++) begin
         if (i % 20 == 19) p = {p, "/"};
         else p = {p, "z"};
      end
      send_path(p, 8'd128);
      send_path("/./../", 8'd2);
      drain();

      while (sent < 2000) begin
         steady = (sent > 900 && sent < 1300);
         if (sent > 1500 && sent < 1520) drain();
         case ($urandom_range(9))
            0, 1: send_beat(2'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                            7'($urandom));
            2: send_beat(OP_COMMIT, 8'($urandom), 1'($urandom), 8'($urandom),
                         7'($urandom));
            3: send_beat(OP_READ, 8'($urandom), 1'($urandom), 8'($urandom),
                         7'($urandom_range(0, 40)));
            default: begin
               send_path(rand_path(),
                         ($urandom_range(4) == 0) ? 8'($urandom) : 8'd128);
               if ($urandom_range(1) == 0)
                  send_beat(OP_READ, 8'($urandom), 1'($urandom), 8'($urandom),
                            7'($urandom_range(0, 30)));
               if ($urandom_range(2) == 0)
                  send_beat(OP_COMMIT, 8'($urandom), 1'($urandom), 8'($urandom),
                            7'($urandom));
            end
         endcase
      end
      drain();
      repeat (600) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("path_canonicalizer_unit: match");
      else $display("path_canonicalizer_unit: mismatch");
      $finish;
   end

   initial begin
      #30ms;
      $display("path_canonicalizer_unit: mismatch");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/pcan_pkg.sv
sv/pcan_ctrl.sv
sv/pcan_dp.sv
sv/path_canonicalizer_unit.sv
sv/pcan_checker.sv
tb/sv/path_canonicalizer_unit_checker.sv
tb/sv/path_canonicalizer_unit_tb.sv
